// File: src/pbm_pkg.sv
// ----------------------------------------------------------------------------
// PBM P4 decoder package
// Shared item types, result codes and header characters.
// ----------------------------------------------------------------------------
`default_nettype none

package pbm_pkg;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_MAGIC  = 2'd0;
  localparam logic [1:0] ERR_HEADER = 2'd1;
  localparam logic [1:0] ERR_TRUNC  = 2'd2;

  localparam logic [7:0] CHAR_P       = 8'h50;
  localparam logic [7:0] CHAR_FOUR    = 8'h34;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  localparam logic [2:0] LAST_BIT = 3'd7;
  localparam logic [3:0] BYTE_BITS = 4'd8;

  localparam int unsigned CMD_DEPTH = 2;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_LINE,
    PH_COMMENT,
    PH_WIDTH,
    PH_HEIGHT,
    PH_DATA,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_DONE,
    TAIL_ERROR
  } tail_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        black;
    logic [1:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [11:0] col;
    logic [11:0] row;
    logic [3:0]  count;
    tail_t       tail;
    logic [1:0]  error_code;
  } cmd_t;

  function automatic logic [7:0] magic_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CHAR_P;
      2'd1:    c = CHAR_FOUR;
      default: c = CHAR_NEWLINE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/pbm_p4_bitmap_decoder.sv
// A taken byte's results pass the command queue, then the output register.
// Throughput: one byte per cycle while the command queue has room; a data byte
// expands to up to eight pixels plus a done or error result, one result per cycle
// while results are popped, so the expander's single output limits pixel data.
// Reset (rst, synchronous): parser returns to the magic check, queue and
// output register empty.
// ----------------------------------------------------------------------------
// PBM P4 bitmap decoder
// Parser front end, command queue and pixel expander back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_p4_bitmap_decoder #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire pbm_pkg::in_item_t  data_in,
  output logic                    empty,
  input  wire logic               pop,
  output pbm_pkg::out_item_t      result
);
  import pbm_pkg::*;

  cmd_t cmd, head;
  logic cmd_push, q_full, q_empty, q_pop;

  pbm_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .data_in (data_in),
    .q_full  (q_full),
    .cmd_push(cmd_push),
    .cmd     (cmd)
  );

  pbm_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_data(cmd),
    .q_full (q_full),
    .rd_en  (q_pop),
    .rd_data(head),
    .q_empty(q_empty)
  );

  pbm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire

// File: src/pbm_front.sv
// ----------------------------------------------------------------------------
// PBM P4 decoder front end
// Parses magic, comments and header, tracks the pixel position and issues
// one expansion command per byte that yields results.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire pbm_pkg::in_item_t data_in,
  input  wire logic              q_full,
  output logic                   cmd_push,
  output pbm_pkg::cmd_t          cmd
);
  import pbm_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  phase_t        phase, phase_next;
  logic [1:0]    magic_pos, magic_pos_next;
  logic [WW-1:0] image_width, image_width_next;
  logic [HW-1:0] image_height, image_height_next;
  logic          digit_seen, digit_seen_next;
  logic [WW-1:0] column, column_next;
  logic [HW-1:0] row, row_next;

  logic          accept;
  logic          is_digit;
  logic [WW+3:0] wacc;
  logic [HW+3:0] hacc;
  logic [WW-1:0] left;
  logic [3:0]    count;
  logic [WW-1:0] col_sum;
  logic [HW:0]   row_inc;
  logic          hit_fail;
  logic [1:0]    fail_code;
  logic          hit_done;
  logic [7:0]    b;

  assign b        = data_in.data_byte;
  assign full     = q_full;
  assign accept   = push && !q_full;
  assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);

  assign wacc = ((WW + 4)'(image_width) << 3) + ((WW + 4)'(image_width) << 1)
              + (WW + 4)'(b[3:0]);
  assign hacc = ((HW + 4)'(image_height) << 3) + ((HW + 4)'(image_height) << 1)
              + (HW + 4)'(b[3:0]);

  assign left    = image_width - column;
  assign col_sum = column + WW'(count);
  assign row_inc = (HW + 1)'(row) + (HW + 1)'(1);

  always_comb begin
    count = (left < WW'(BYTE_BITS)) ? left[3:0] : BYTE_BITS;
  end

  // next state and header registers
  always_comb begin
    phase_next        = phase;
    magic_pos_next    = magic_pos;
    image_width_next  = image_width;
    image_height_next = image_height;
    digit_seen_next   = digit_seen;
    column_next       = column;
    row_next          = row;
    hit_fail          = 1'b0;
    fail_code         = ERR_HEADER;
    hit_done          = 1'b0;
    case (phase)
      PH_MAGIC: begin
        if (b != magic_char(magic_pos)) begin
          hit_fail   = 1'b1;
          fail_code  = ERR_MAGIC;
          phase_next = PH_FAIL;
        end else if (magic_pos == 2'd2) begin
          magic_pos_next = 2'd0;
          phase_next     = PH_LINE;
        end else begin
          magic_pos_next = magic_pos + 2'd1;
        end
      end
      PH_COMMENT: begin
        if (b == CHAR_NEWLINE) phase_next = PH_LINE;
      end
      PH_LINE, PH_WIDTH: begin
        if (phase == PH_LINE && b == CHAR_HASH) begin
          phase_next = PH_COMMENT;
        end else begin
          phase_next = PH_WIDTH;
          if (is_digit) begin
            digit_seen_next  = 1'b1;
            image_width_next = wacc[WW-1:0];
            if (wacc > (WW + 4)'(MAX_WIDTH)) begin
              hit_fail   = 1'b1;
              phase_next = PH_FAIL;
            end
          end else if (b == CHAR_SPACE && digit_seen) begin
            digit_seen_next = 1'b0;
            phase_next      = PH_HEIGHT;
          end else begin
            hit_fail   = 1'b1;
            phase_next = PH_FAIL;
          end
        end
      end
      PH_HEIGHT: begin
        if (is_digit) begin
          digit_seen_next   = 1'b1;
          image_height_next = hacc[HW-1:0];
          if (hacc > (HW + 4)'(MAX_HEIGHT)) begin
            hit_fail   = 1'b1;
            phase_next = PH_FAIL;
          end
        end else if (b == CHAR_NEWLINE && digit_seen) begin
          digit_seen_next = 1'b0;
          column_next     = '0;
          row_next        = '0;
          if (image_width == '0 || image_height == '0) begin
            hit_done   = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          hit_fail   = 1'b1;
          phase_next = PH_FAIL;
        end
      end
      PH_DATA: begin
        column_next = col_sum;
        if (col_sum >= image_width) begin
          column_next = '0;
          row_next    = row_inc[HW-1:0];
          if (row_inc >= (HW + 1)'(image_height)) begin
            hit_done   = 1'b1;
            phase_next = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // command to the back end
  always_comb begin
    cmd.data_byte  = b;
    cmd.col        = 12'(column);
    cmd.row        = 12'(row);
    cmd.count      = (phase == PH_DATA) ? count : 4'd0;
    cmd.tail       = TAIL_NONE;
    cmd.error_code = '0;
    if (hit_fail) begin
      cmd.tail       = TAIL_ERROR;
      cmd.error_code = fail_code;
    end else if (hit_done) begin
      cmd.tail = TAIL_DONE;
    end else if (data_in.end_of_file && phase_next != PH_DONE && phase_next != PH_FAIL) begin
      cmd.tail = TAIL_ERROR;
      case (phase_next)
        PH_MAGIC: cmd.error_code = ERR_MAGIC;
        PH_DATA:  cmd.error_code = ERR_TRUNC;
        default:  cmd.error_code = ERR_HEADER;
      endcase
    end
    cmd_push = accept && (cmd.count != 4'd0 || cmd.tail != TAIL_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && data_in.end_of_file)) begin
      phase        <= PH_MAGIC;
      magic_pos    <= '0;
      image_width  <= '0;
      image_height <= '0;
      digit_seen   <= 1'b0;
      column       <= '0;
      row          <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      magic_pos    <= magic_pos_next;
      image_width  <= image_width_next;
      image_height <= image_height_next;
      digit_seen   <= digit_seen_next;
      column       <= column_next;
      row          <= row_next;
    end
  end

endmodule

`default_nettype wire

// File: src/pbm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// PBM P4 decoder command queue
// Short register queue between the parser and the pixel expander.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire pbm_pkg::cmd_t wr_data,
  output logic               q_full,
  input  wire logic          rd_en,
  output pbm_pkg::cmd_t      rd_data,
  output logic               q_empty
);
  import pbm_pkg::*;

  localparam int unsigned PW = $clog2(CMD_DEPTH);
  localparam int unsigned CW = $clog2(CMD_DEPTH + 1);

  cmd_t          slots [CMD_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic          do_wr, do_rd;

  assign q_full  = (fill == CW'(CMD_DEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_wr && !do_rd) fill <= fill + CW'(1);
      else if (do_rd && !do_wr) fill <= fill - CW'(1);
    end
  end

endmodule

`default_nettype wire

// File: src/pbm_back.sv
// ----------------------------------------------------------------------------
// PBM P4 decoder back end
// Expands each command into pixel, done and error results, one per cycle
// while results are popped, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pbm_pkg::cmd_t head,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               empty,
  input  wire logic          pop,
  output pbm_pkg::out_item_t result
);
  import pbm_pkg::*;

  logic [3:0] idx;
  logic [3:0] total;
  logic       load;
  logic       last;
  logic       out_valid;
  out_item_t  cur;

  assign total = head.count + ((head.tail != TAIL_NONE) ? 4'd1 : 4'd0);
  assign last  = (idx == total - 4'd1);
  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load && last;
  assign empty = !out_valid;

  always_comb begin
    cur.kind        = KIND_PIXEL;
    cur.pixel_x     = '0;
    cur.pixel_y     = '0;
    cur.black       = 1'b0;
    cur.error_code  = '0;
    cur.last_of_run = last;
    if (idx < head.count) begin
      cur.pixel_x = head.col + 12'(idx);
      cur.pixel_y = head.row;
      cur.black   = head.data_byte[LAST_BIT - idx[2:0]];
    end else begin
      case (head.tail)
        TAIL_DONE:  cur.kind = KIND_DONE;
        TAIL_ERROR: begin
          cur.kind       = KIND_ERROR;
          cur.error_code = head.error_code;
        end
        default:    cur.kind = KIND_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last ? 4'd0 : idx + 4'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: src/pbm_checker.sv
// ----------------------------------------------------------------------------
// PBM P4 decoder checker
// Port-level checks on reset, result hold and result field coding.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire pbm_pkg::out_item_t result
);
  import pbm_pkg::*;

  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> empty && !full)
    else $error("queue not clear after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.kind == KIND_PIXEL || result.kind == KIND_DONE
            || result.kind == KIND_ERROR)
    else $error("bad result kind");

  a_non_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind != KIND_PIXEL |->
      result.pixel_x == '0 && result.pixel_y == '0 && !result.black)
    else $error("coordinates set on non-pixel result");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind != KIND_ERROR |-> result.error_code == '0)
    else $error("error code set on non-error result");

endmodule

bind pbm_p4_bitmap_decoder pbm_checker u_checker (.*);

`default_nettype wire
